@@ hdl/lzs_pkg.sv @@
// ============================================================================
// LZS decompressor package
// Shared types and constants for the LZS stream decompressor core.
// ============================================================================
package lzs_pkg;

    // History window and counter sizes.
    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int COUNT_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int BITBUF_W   = 11;
    localparam int BITCNT_W   = 4;
    localparam int COPY_W     = 5;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = {COUNT_W{1'b1}};

    // Field lengths of the token grammar, in bits.
    localparam logic [BITCNT_W-1:0] LIT_BITS   = 4'd8;
    localparam logic [BITCNT_W-1:0] OFF7_BITS  = 4'd7;
    localparam logic [BITCNT_W-1:0] OFF11_BITS = 4'd11;
    localparam logic [BITCNT_W-1:0] LEN_BITS   = 4'd2;
    localparam logic [BITCNT_W-1:0] NIB_BITS   = 4'd4;

    // Copy lengths.
    localparam logic [COPY_W-1:0] LEN_BASE_A = 5'd2;
    localparam logic [COPY_W-1:0] LEN_BASE_B = 5'd5;
    localparam logic [COPY_W-1:0] LEN_EXT    = 5'd8;
    localparam logic [1:0]        LEN_ESC    = 2'b11;
    localparam logic [3:0]        NIB_CONT   = 4'hF;

    // Token parser phase.
    typedef enum logic [2:0] {
        PH_FLAG,
        PH_LIT,
        PH_KIND,
        PH_OFF7,
        PH_OFF11,
        PH_LENA,
        PH_LENB,
        PH_NIB
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK,
        ST_END,
        ST_LIMIT,
        ST_FAR
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_COPY_RD,
        S_COPY_WR,
        S_FINISH
    } seq_state_t;

    // One result word without its end-of-run mark.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        status_t           status;
    } result_t;

endpackage

@@ hdl/lzs_stream_decompressor_core.sv @@
// ============================================================================
// LZS stream decompressor core
// Parses LZS (Stac) tokens from compressed bytes, most significant bit first,
// and emits decoded bytes from literals and copies out of a 2048-byte history.
// ============================================================================
//
//  Channel  | Signals                                        | Handshake
//  ---------+------------------------------------------------+-----------------
//  input    | in_byte, in_last                               | in_valid/in_ready
//  output   | out_byte, byte_valid, run_last, status         | out_valid/out_ready
//  config   | cfg_wr_data (output limit)                     | cfg_wr_en, no wait
//
// An input word is accepted in the idle state. Its eight bits are then parsed
// in turn in the bit state, which waits while the hold stage cannot take a
// result. Each copied byte is a history read, then a write and emit; each copy
// release closes in the copy-read state, and the word closes in the finish
// state. A word that arrives after the stream has halted goes straight to the
// finish state. The copy loop runs through the single-port-read history RAM.
// Reset clears all control state; history contents are undefined until
// written. A stalled output stops the sequencer only when both the output
// register and the one-word hold stage are full.
//
module lzs_stream_decompressor_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lzs_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lzs_pkg::BYTE_W-1:0]   out_byte,
    output logic                         byte_valid,
    output logic                         run_last,
    output logic [1:0]                   status,
    input  logic                         cfg_wr_en,
    input  logic [lzs_pkg::COUNT_W-1:0]  cfg_wr_data
);

    // Sequencer and input word.
    lzs_pkg::seq_state_t              state_reg, state_next;
    logic [lzs_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [3:0]                       bits_reg, bits_next;
    logic                             last_reg, last_next;

    // Stream state.
    logic [lzs_pkg::HIST_AW-1:0]      wp_reg, wp_next;
    logic [lzs_pkg::BITBUF_W-1:0]     buf_reg, buf_next;
    logic [lzs_pkg::BITCNT_W-1:0]     cnt_reg, cnt_next;
    lzs_pkg::phase_t                  phase_reg, phase_next;
    logic [lzs_pkg::HIST_AW-1:0]      offset_reg, offset_next;
    logic [lzs_pkg::COPY_W-1:0]       copy_reg, copy_next;
    logic [lzs_pkg::COUNT_W-1:0]      produced_reg, produced_next;
    logic                             ended_reg, ended_next;
    logic [lzs_pkg::COUNT_W-1:0]      limit_reg;

    // Hold stage and output register.
    lzs_pkg::result_t                 hold_reg, hold_next;
    logic                             hold_v_reg, hold_v_next;
    lzs_pkg::result_t                 out_reg, out_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_v_reg, out_v_next;

    // History memory.
    logic [lzs_pkg::BYTE_W-1:0]       hist_mem [lzs_pkg::HIST_DEPTH];
    logic [lzs_pkg::BYTE_W-1:0]       rdata_reg;
    logic                             hist_we;
    logic [lzs_pkg::BYTE_W-1:0]       hist_wdata;
    logic                             hist_re;
    logic [lzs_pkg::HIST_AW-1:0]      hist_raddr;

    // Per-bit decode helpers.
    logic                             cur_bit;
    logic [lzs_pkg::BITBUF_W-1:0]     buf_in;
    logic [lzs_pkg::BITCNT_W-1:0]     cnt_in;
    logic [lzs_pkg::HIST_AW-1:0]      off_in;
    logic                             slot_free;
    logic                             push_ok;
    logic                             push_en;
    lzs_pkg::result_t                 push_data;
    logic                             flush;
    logic                             limit_hit;
    logic                             halt;
    lzs_pkg::status_t                 halt_status;
    logic                             lit_emit;
    logic                             copy_start;
    logic [lzs_pkg::COPY_W-1:0]       copy_len;

    assign cur_bit    = shift_reg[lzs_pkg::BYTE_W-1];
    assign buf_in     = {buf_reg[lzs_pkg::BITBUF_W-2:0], cur_bit};
    assign cnt_in     = cnt_reg + 1'b1;
    assign off_in     = buf_in[lzs_pkg::HIST_AW-1:0];
    assign slot_free  = !out_v_reg || out_ready;
    assign push_ok    = !hold_v_reg || slot_free;
    assign limit_hit  = (produced_reg >= limit_reg);
    assign hist_raddr = wp_reg - offset_reg;

    assign in_ready   = (state_reg == lzs_pkg::S_IDLE);
    assign out_valid  = out_v_reg;
    assign out_byte   = out_reg.data;
    assign byte_valid = out_reg.valid;
    assign status     = out_reg.status;
    assign run_last   = out_last_reg;

    // Token decode of the current bit. Only meaningful in the bit state.
    always_comb
    begin
        phase_next  = phase_reg;
        buf_next    = buf_in;
        cnt_next    = cnt_in;
        offset_next = offset_reg;
        halt        = 1'b0;
        halt_status = lzs_pkg::ST_OK;
        lit_emit    = 1'b0;
        copy_start  = 1'b0;
        copy_len    = '0;
        case (phase_reg)
            lzs_pkg::PH_FLAG:
            begin
                phase_next = cur_bit ? lzs_pkg::PH_KIND : lzs_pkg::PH_LIT;
                buf_next   = '0;
                cnt_next   = '0;
            end
            lzs_pkg::PH_LIT:
            begin
                if (cnt_in == lzs_pkg::LIT_BITS)
                begin
                    phase_next = lzs_pkg::PH_FLAG;
                    buf_next   = '0;
                    cnt_next   = '0;
                    lit_emit   = 1'b1;
                end
            end
            lzs_pkg::PH_KIND:
            begin
                phase_next = cur_bit ? lzs_pkg::PH_OFF7 : lzs_pkg::PH_OFF11;
                buf_next   = '0;
                cnt_next   = '0;
            end
            lzs_pkg::PH_OFF7, lzs_pkg::PH_OFF11:
            begin
                if ((phase_reg == lzs_pkg::PH_OFF7 && cnt_in == lzs_pkg::OFF7_BITS) ||
                    (phase_reg == lzs_pkg::PH_OFF11 && cnt_in == lzs_pkg::OFF11_BITS))
                begin
                    if (off_in == '0)
                    begin
                        halt        = 1'b1;
                        halt_status = lzs_pkg::ST_END;
                    end
                    else if (lzs_pkg::COUNT_W'(off_in) > produced_reg)
                    begin
                        halt        = 1'b1;
                        halt_status = lzs_pkg::ST_FAR;
                    end
                    else
                    begin
                        offset_next = off_in;
                        phase_next  = lzs_pkg::PH_LENA;
                        buf_next    = '0;
                        cnt_next    = '0;
                    end
                end
            end
            lzs_pkg::PH_LENA:
            begin
                if (cnt_in == lzs_pkg::LEN_BITS)
                begin
                    buf_next = '0;
                    cnt_next = '0;
                    if (buf_in[1:0] == lzs_pkg::LEN_ESC)
                    begin
                        phase_next = lzs_pkg::PH_LENB;
                    end
                    else
                    begin
                        phase_next = lzs_pkg::PH_FLAG;
                        copy_start = 1'b1;
                        copy_len   = lzs_pkg::LEN_BASE_A + lzs_pkg::COPY_W'(buf_in[1:0]);
                    end
                end
            end
            lzs_pkg::PH_LENB:
            begin
                if (cnt_in == lzs_pkg::LEN_BITS)
                begin
                    buf_next   = '0;
                    cnt_next   = '0;
                    copy_start = 1'b1;
                    if (buf_in[1:0] == lzs_pkg::LEN_ESC)
                    begin
                        phase_next = lzs_pkg::PH_NIB;
                        copy_len   = lzs_pkg::LEN_EXT;
                    end
                    else
                    begin
                        phase_next = lzs_pkg::PH_FLAG;
                        copy_len   = lzs_pkg::LEN_BASE_B + lzs_pkg::COPY_W'(buf_in[1:0]);
                    end
                end
            end
            lzs_pkg::PH_NIB:
            begin
                if (cnt_in == lzs_pkg::NIB_BITS)
                begin
                    buf_next   = '0;
                    cnt_next   = '0;
                    copy_start = 1'b1;
                    copy_len   = lzs_pkg::COPY_W'(buf_in[3:0]);
                    phase_next = (buf_in[3:0] == lzs_pkg::NIB_CONT) ? lzs_pkg::PH_NIB
                                                                    : lzs_pkg::PH_FLAG;
                end
            end
            default:
            begin
                phase_next = lzs_pkg::PH_FLAG;
                buf_next   = '0;
                cnt_next   = '0;
            end
        endcase
    end

    // Sequencer: next state, stream updates and result pushes.
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bits_next      = bits_reg;
        last_next      = last_reg;
        wp_next        = wp_reg;
        copy_next      = copy_reg;
        produced_next  = produced_reg;
        ended_next     = ended_reg;
        push_en        = 1'b0;
        push_data      = '{data: '0, valid: 1'b0, status: lzs_pkg::ST_OK};
        flush          = 1'b0;
        hist_we        = 1'b0;
        hist_wdata     = rdata_reg;
        hist_re        = 1'b0;

        case (state_reg)
            lzs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    shift_next = in_byte;
                    last_next  = in_last;
                    bits_next  = 4'd8;
                    state_next = ended_reg ? lzs_pkg::S_FINISH : lzs_pkg::S_BIT;
                end
            end
            lzs_pkg::S_BIT:
            begin
                if (push_ok)
                begin
                    shift_next = shift_reg << 1;
                    bits_next  = bits_reg - 1'b1;
                    state_next = (bits_reg == 4'd1) ? lzs_pkg::S_FINISH : lzs_pkg::S_BIT;
                    if (halt)
                    begin
                        push_en    = 1'b1;
                        push_data  = '{data: '0, valid: 1'b0, status: halt_status};
                        ended_next = 1'b1;
                        state_next = lzs_pkg::S_FINISH;
                    end
                    else if (lit_emit)
                    begin
                        push_en = 1'b1;
                        if (limit_hit)
                        begin
                            push_data  = '{data: '0, valid: 1'b0, status: lzs_pkg::ST_LIMIT};
                            ended_next = 1'b1;
                            state_next = lzs_pkg::S_FINISH;
                        end
                        else
                        begin
                            push_data     = '{data: buf_in[lzs_pkg::BYTE_W-1:0], valid: 1'b1,
                                              status: lzs_pkg::ST_OK};
                            hist_we       = 1'b1;
                            hist_wdata    = buf_in[lzs_pkg::BYTE_W-1:0];
                            wp_next       = wp_reg + 1'b1;
                            produced_next = produced_reg + 1'b1;
                        end
                    end
                    else if (copy_start)
                    begin
                        copy_next  = copy_len;
                        state_next = lzs_pkg::S_COPY_RD;
                    end
                end
            end
            lzs_pkg::S_COPY_RD:
            begin
                if (copy_reg == '0)
                begin
                    state_next = (bits_reg == 4'd0) ? lzs_pkg::S_FINISH : lzs_pkg::S_BIT;
                end
                else
                begin
                    hist_re    = 1'b1;
                    state_next = lzs_pkg::S_COPY_WR;
                end
            end
            lzs_pkg::S_COPY_WR:
            begin
                if (push_ok)
                begin
                    push_en = 1'b1;
                    if (limit_hit)
                    begin
                        push_data  = '{data: '0, valid: 1'b0, status: lzs_pkg::ST_LIMIT};
                        ended_next = 1'b1;
                        copy_next  = '0;
                        state_next = lzs_pkg::S_FINISH;
                    end
                    else
                    begin
                        push_data     = '{data: rdata_reg, valid: 1'b1, status: lzs_pkg::ST_OK};
                        hist_we       = 1'b1;
                        wp_next       = wp_reg + 1'b1;
                        produced_next = produced_reg + 1'b1;
                        copy_next     = copy_reg - 1'b1;
                        state_next    = lzs_pkg::S_COPY_RD;
                    end
                end
            end
            lzs_pkg::S_FINISH:
            begin
                // The held result is the last one of this word.
                if (!hold_v_reg || slot_free)
                begin
                    flush      = hold_v_reg;
                    state_next = lzs_pkg::S_IDLE;
                    if (last_reg)
                    begin
                        wp_next       = '0;
                        copy_next     = '0;
                        produced_next = '0;
                        ended_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = lzs_pkg::S_IDLE;
            end
        endcase
    end

    // Hold stage and output register. A new result pushes the held one out,
    // so the end-of-run mark can be set on whichever result comes last.
    always_comb
    begin
        hold_next     = hold_reg;
        hold_v_next   = hold_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !out_ready;
        if (push_en)
        begin
            if (hold_v_reg)
            begin
                out_next      = hold_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            hold_next   = push_data;
            hold_v_next = 1'b1;
        end
        if (flush)
        begin
            out_next      = hold_reg;
            out_last_next = 1'b1;
            out_v_next    = 1'b1;
            hold_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lzs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and stream state. The parser fields advance only on a bit that
    // is actually taken; the end of a final word clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg     <= '0;
            last_reg     <= 1'b0;
            wp_reg       <= '0;
            buf_reg      <= '0;
            cnt_reg      <= '0;
            phase_reg    <= lzs_pkg::PH_FLAG;
            offset_reg   <= '0;
            copy_reg     <= '0;
            produced_reg <= '0;
            ended_reg    <= 1'b0;
            limit_reg    <= lzs_pkg::LIMIT_RESET;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            bits_reg     <= bits_next;
            last_reg     <= last_next;
            wp_reg       <= wp_next;
            copy_reg     <= copy_next;
            produced_reg <= produced_next;
            ended_reg    <= ended_next;
            hold_v_reg   <= hold_v_next;
            out_v_reg    <= out_v_next;
            out_last_reg <= out_last_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (state_reg == lzs_pkg::S_FINISH && state_next == lzs_pkg::S_IDLE && last_reg)
            begin
                buf_reg    <= '0;
                cnt_reg    <= '0;
                phase_reg  <= lzs_pkg::PH_FLAG;
                offset_reg <= '0;
            end
            else if (state_reg == lzs_pkg::S_BIT && push_ok)
            begin
                buf_reg    <= buf_next;
                cnt_reg    <= cnt_next;
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

    // History RAM: one write port at the write pointer, one registered read.
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_reg] <= hist_wdata;
        end
        if (hist_re)
        begin
            rdata_reg <= hist_mem[hist_raddr];
        end
    end

    // A new word is taken only after the previous run has fully left the hold stage.
    a_ready_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !hold_v_reg)
        else $error("input accepted while a result is still held");

    // Data results always carry an ok status.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (status == lzs_pkg::ST_OK))
        else $error("data result with nonzero status");

    // A halting status is always the final result of its word.
    a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != lzs_pkg::ST_OK) |-> run_last)
        else $error("status result not marked last");

    // The bit state always has at least one bit left to parse.
    a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzs_pkg::S_BIT) |-> (bits_reg != 4'd0))
        else $error("bit state entered with no bits left");

    // A copy step that emits a byte advances the write pointer by one.
    a_copy_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzs_pkg::S_COPY_WR && push_ok && !limit_hit)
        |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance on a copied byte");

endmodule
